// ----- hw/rtl/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers for the RTL of the hash matcher.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ----- hw/rtl/trhm_pkg.sv -----
// ============================================================================
// Token rolling hash matcher package
// Widths, character codes, register indexes and the response record.
// ============================================================================
`default_nettype none

package trhm_pkg;

   localparam int HASH_W    = 64;
   localparam int CODE_W    = 8;
   localparam int WL_W      = 7;
   localparam int COUNT_W   = 32;
   localparam int CSR_IDX_W = 2;

   localparam int DEF_MAX_WINDOW = 64;
   localparam int DEF_RSP_DEPTH  = 8;

   typedef logic [HASH_W-1:0]  hash_type;
   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam hash_type HASH_BASE   = hash_type'(31);
   localparam code_type CLOSE_CODE  = 8'h29;
   localparam code_type UPPER_FIRST = 8'h41;
   localparam code_type UPPER_LAST  = 8'h5A;

   localparam logic [WL_W-1:0] DEF_WINDOW_LENGTH = 7'd1;
   localparam hash_type        DEF_PATTERN_HASH  = hash_type'(0);
   localparam hash_type        DEF_SEED_POWER    = hash_type'(31);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LENGTH = 2'd0,
      CSR_PATTERN_HASH  = 2'd1,
      CSR_SEED_POWER    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic      token_done;
      logic      match;
      count_type match_count;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ----- hw/rtl/trhm_if.sv -----
// ============================================================================
// Token rolling hash matcher channels
// Valid/ready interfaces for text input, responses and register writes.
// ============================================================================
`default_nettype none

interface trhm_req_if import trhm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   char_code;
   logic                start_of_text;

   modport source (output valid, char_code, start_of_text, input ready);
   modport sink   (input valid, char_code, start_of_text, output ready);
endinterface

interface trhm_rsp_if import trhm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                token_done;
   logic                match;
   logic [COUNT_W-1:0]  match_count;

   modport source (output valid, token_done, match, match_count, input ready);
   modport sink   (input valid, token_done, match, match_count, output ready);
endinterface

interface trhm_csr_if import trhm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [HASH_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/trhm_rsp_fifo.sv -----
// ============================================================================
// Response queue
// Small register queue that holds finished responses until they transfer.
// ============================================================================
`default_nettype none

module trhm_rsp_fifo import trhm_pkg::*; #(
   parameter int DEPTH = DEF_RSP_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsp_payload_type    push_data,
   trhm_rsp_if.source         rsp_ch
);

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);

   rsp_payload_type   q_mem [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic              pop;
   rsp_payload_type   head;

   assign pop  = rsp_ch.valid && rsp_ch.ready;
   assign head = q_mem[rd_ptr_ff];

   assign rsp_ch.valid       = (level_ff != '0);
   assign rsp_ch.token_done  = head.token_done;
   assign rsp_ch.match       = head.match;
   assign rsp_ch.match_count = head.match_count;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (LVL_W'(wr_ptr_ff) == LVL_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (LVL_W'(rd_ptr_ff) == LVL_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + LVL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/token_rolling_hash_matcher.sv -----
// ============================================================================
// Token rolling hash matcher
// Folds upper-case letters into token hashes, keeps a rolling hash over the
// last window_length closed tokens and counts windows equal to the pattern.
// ============================================================================
//
// Channel   Direction  Payload                                   Transfer
// req_ch    in         char_code[7:0], start_of_text             valid && ready
// rsp_ch    out        token_done, match, match_count[31:0]      valid && ready
// csr_ch    in         index[1:0], data[63:0]                    valid && ready
//
// One character is taken per cycle while req_ch.ready is high. Each response
// is built through the history memory read, the 64-bit old-token product
// split into three 32-bit multipliers, and then the window hash
// recurrence. Input is held back only while RSP_DEPTH responses are in flight
// or queued. Reset needs no clearing pass: a history entry is read only after
// it was written since the last start of text.
//
`default_nettype none
`include "assert_macros.svh"

module token_rolling_hash_matcher import trhm_pkg::*; #(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int RSP_DEPTH  = DEF_RSP_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   trhm_req_if.sink     req_ch,
   trhm_rsp_if.source   rsp_ch,
   trhm_csr_if.sink     csr_ch
);

   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CMP_W  = (CNT_W > WL_W) ? CNT_W : WL_W;
   localparam int IDX_W  = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
   localparam int CRED_W = $clog2(RSP_DEPTH + 1);
   localparam int HALF_W = HASH_W / 2;

   // Configuration registers.
   logic [WL_W-1:0]    wl_ff;
   hash_type           pat_ff;
   hash_type           pow_ff;

   // Text state.
   hash_type           tok_acc_ff, tok_acc_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   seen_ff, seen_in;
   hash_type           win_ff, win_in;
   count_type          cnt_ff, cnt_in;
   logic [CRED_W-1:0]  inflight_ff, inflight_in;

   // Token history memory.
   hash_type           hist_mem [MAX_WINDOW];
   hash_type           hist_rd_ff;

   // Character decode and control for the incoming transfer.
   logic               accept;
   logic               pop;
   logic               start;
   logic               is_close;
   logic               is_upper;
   hash_type           tok_cur;
   logic [PTR_W-1:0]   ptr_cur;
   logic [CNT_W-1:0]   seen_cur;
   logic [CMP_W-1:0]   wl_ext;
   logic [CNT_W-1:0]   len_eff;
   logic [CNT_W-1:0]   seen_step;
   logic               use_old;
   logic               elig;
   logic [IDX_W-1:0]   ptr_ext;
   logic [IDX_W-1:0]   len_ext;
   logic [PTR_W-1:0]   old_idx;
   logic [PTR_W-1:0]   ptr_wrap;

   // Stage 1: history data returns.
   logic               s1_v_ff;
   logic               s1_start_ff, s1_close_ff, s1_use_old_ff, s1_elig_ff;
   hash_type           s1_tok_ff;
   hash_type           old_val;

   // Stage 2: partial products of old token times seed power.
   logic               s2_v_ff;
   logic               s2_start_ff, s2_close_ff, s2_elig_ff;
   hash_type           s2_tok_ff;
   hash_type           s2_prod_ll_ff;
   logic [HALF_W-1:0]  s2_prod_hl_ff, s2_prod_lh_ff;
   hash_type           prod_ll_in;
   logic [HALF_W-1:0]  prod_hl_in, prod_lh_in;

   // Stage 3: new token minus departing term.
   logic               s3_v_ff;
   logic               s3_start_ff, s3_close_ff, s3_elig_ff;
   hash_type           s3_diff_ff;
   hash_type           prod_full;
   hash_type           diff_in;
   hash_type           win_base;

   // Stage 4: compare and count.
   logic               s4_v_ff;
   logic               s4_start_ff, s4_close_ff, s4_elig_ff;
   hash_type           s4_hash_ff;
   count_type          cnt_base;
   logic               hit;
   rsp_payload_type    push_data;
   logic [2:0]         pipe_occ;

   // ------------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------------
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff  <= DEF_WINDOW_LENGTH;
         pat_ff <= DEF_PATTERN_HASH;
         pow_ff <= DEF_SEED_POWER;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_WINDOW_LENGTH: wl_ff  <= csr_ch.data[WL_W-1:0];
            CSR_PATTERN_HASH:  pat_ff <= csr_ch.data;
            CSR_SEED_POWER:    pow_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Character decode, token accumulation and history addressing
   // ------------------------------------------------------------------------
   assign accept = req_ch.valid && req_ch.ready;
   assign pop    = rsp_ch.valid && rsp_ch.ready;
   assign start  = req_ch.start_of_text;

   // A start of text clears the token, the pointer and the seen count first.
   assign tok_cur  = start ? '0 : tok_acc_ff;
   assign ptr_cur  = start ? '0 : ptr_ff;
   assign seen_cur = start ? '0 : seen_ff;

   assign is_close = (req_ch.char_code == CLOSE_CODE);
   assign is_upper = (req_ch.char_code >= UPPER_FIRST) && (req_ch.char_code <= UPPER_LAST);

   assign wl_ext = CMP_W'(wl_ff);

   always_comb begin
      if (wl_ff == '0) begin
         len_eff = CNT_W'(1);
      end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
         len_eff = CNT_W'(MAX_WINDOW);
      end else begin
         len_eff = CNT_W'(wl_ext);
      end
   end

   assign use_old   = (seen_cur >= len_eff);
   assign seen_step = (seen_cur < len_eff) ? seen_cur + CNT_W'(1) : len_eff;
   assign elig      = (seen_step >= len_eff);

   assign ptr_ext = IDX_W'(ptr_cur);
   assign len_ext = IDX_W'(len_eff);

   // The departing token sits window-length slots behind the write pointer.
   always_comb begin
      if (ptr_ext >= len_ext) begin
         old_idx = PTR_W'(ptr_ext - len_ext);
      end else begin
         old_idx = PTR_W'(ptr_ext + IDX_W'(MAX_WINDOW) - len_ext);
      end
   end

   assign ptr_wrap = (ptr_ext + IDX_W'(1) == IDX_W'(MAX_WINDOW)) ? '0 : ptr_cur + PTR_W'(1);

   always_comb begin
      tok_acc_in = tok_acc_ff;
      ptr_in     = ptr_ff;
      seen_in    = seen_ff;
      if (accept) begin
         tok_acc_in = tok_cur;
         ptr_in     = ptr_cur;
         seen_in    = seen_cur;
         if (is_close) begin
            tok_acc_in = '0;
            ptr_in     = ptr_wrap;
            seen_in    = seen_step;
         end else if (is_upper) begin
            tok_acc_in = tok_cur * HASH_BASE + HASH_W'(req_ch.char_code);
         end
      end
   end

   // Read happens before write, so a full-length window still sees the old entry.
   always_ff @(posedge clock) begin
      if (accept && is_close) begin
         hist_mem[ptr_cur] <= tok_cur;
      end
      if (accept) begin
         hist_rd_ff <= hist_mem[old_idx];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1 to 2: product of departing token and seed power, mod 2^64
   // ------------------------------------------------------------------------
   assign old_val    = s1_use_old_ff ? hist_rd_ff : '0;
   assign prod_ll_in = HASH_W'(old_val[HALF_W-1:0]) * HASH_W'(pow_ff[HALF_W-1:0]);
   assign prod_hl_in = old_val[HASH_W-1:HALF_W] * pow_ff[HALF_W-1:0];
   assign prod_lh_in = old_val[HALF_W-1:0] * pow_ff[HASH_W-1:HALF_W];

   // ------------------------------------------------------------------------
   // Stage 2 to 3: new token minus departing term
   // ------------------------------------------------------------------------
   assign prod_full = s2_prod_ll_ff + {s2_prod_hl_ff + s2_prod_lh_ff, {HALF_W{1'b0}}};
   assign diff_in   = s2_tok_ff - prod_full;

   // ------------------------------------------------------------------------
   // Stage 3: window hash recurrence
   // ------------------------------------------------------------------------
   assign win_base = s3_start_ff ? '0 : win_ff;

   always_comb begin
      win_in = win_ff;
      if (s3_v_ff) begin
         win_in = s3_close_ff ? win_base * HASH_BASE + s3_diff_ff : win_base;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: pattern compare and saturating count
   // ------------------------------------------------------------------------
   assign cnt_base = s4_start_ff ? '0 : cnt_ff;
   assign hit      = s4_close_ff && s4_elig_ff && (s4_hash_ff == pat_ff);

   always_comb begin
      cnt_in = cnt_ff;
      if (s4_v_ff) begin
         cnt_in = (hit && (cnt_base != '1)) ? cnt_base + COUNT_W'(1) : cnt_base;
      end
   end

   assign push_data.token_done  = s4_close_ff;
   assign push_data.match       = hit;
   assign push_data.match_count = cnt_in;

   // ------------------------------------------------------------------------
   // Flow control: every accepted character holds a queue slot until its
   // response transfers, so the queue never overflows.
   // ------------------------------------------------------------------------
   assign req_ch.ready = (inflight_ff < CRED_W'(RSP_DEPTH));

   always_comb begin
      inflight_in = inflight_ff;
      if (accept && !pop) begin
         inflight_in = inflight_ff + CRED_W'(1);
      end else if (pop && !accept) begin
         inflight_in = inflight_ff - CRED_W'(1);
      end
   end

   assign pipe_occ = 3'($countones({s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff}));

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_acc_ff  <= '0;
         ptr_ff      <= '0;
         seen_ff     <= '0;
         win_ff      <= '0;
         cnt_ff      <= '0;
         inflight_ff <= '0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         s4_v_ff     <= 1'b0;
      end else begin
         tok_acc_ff  <= tok_acc_in;
         ptr_ff      <= ptr_in;
         seen_ff     <= seen_in;
         win_ff      <= win_in;
         cnt_ff      <= cnt_in;
         inflight_ff <= inflight_in;
         s1_v_ff     <= accept;
         s2_v_ff     <= s1_v_ff;
         s3_v_ff     <= s2_v_ff;
         s4_v_ff     <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_start_ff   <= start;
      s1_close_ff   <= is_close;
      s1_use_old_ff <= use_old;
      s1_elig_ff    <= elig;
      s1_tok_ff     <= tok_cur;

      s2_start_ff   <= s1_start_ff;
      s2_close_ff   <= s1_close_ff;
      s2_elig_ff    <= s1_elig_ff;
      s2_tok_ff     <= s1_tok_ff;
      s2_prod_ll_ff <= prod_ll_in;
      s2_prod_hl_ff <= prod_hl_in;
      s2_prod_lh_ff <= prod_lh_in;

      s3_start_ff   <= s2_start_ff;
      s3_close_ff   <= s2_close_ff;
      s3_elig_ff    <= s2_elig_ff;
      s3_diff_ff    <= diff_in;

      s4_start_ff   <= s3_start_ff;
      s4_close_ff   <= s3_close_ff;
      s4_elig_ff    <= s3_elig_ff;
      s4_hash_ff    <= win_in;
   end

   // ------------------------------------------------------------------------
   // Response queue
   // ------------------------------------------------------------------------
   trhm_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s4_v_ff),
      .push_data (push_data),
      .rsp_ch    (rsp_ch)
   );

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `ASSERT_CLK(a_credit_covers_pipe, clock, reset, inflight_ff >= CRED_W'(pipe_occ))
   `ASSERT_CLK(a_rsp_has_credit, clock, reset, rsp_ch.valid |-> inflight_ff != '0)
   `ASSERT_CLK(a_close_clears_token, clock, reset, accept && is_close |=> tok_acc_ff == '0)
   `ASSERT_NEVER(a_match_without_close, clock, reset, rsp_ch.valid && rsp_ch.match && !rsp_ch.token_done)

endmodule

`default_nettype wire
